// ===== hdl/sine_pwm_bridge_driver_macros.svh =====
// Assertion macros for the design files; spbd_back uses them.
`ifndef SINE_PWM_BRIDGE_DRIVER_MACROS_SVH
`define SINE_PWM_BRIDGE_DRIVER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SPBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SPBD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spbd_pkg.sv =====
`timescale 1ns / 1ps
package spbd_pkg;

  localparam int SINE_ADDR_BITS = 10;
  localparam int PHASE_BITS     = 32;
  localparam int COUNT_BITS     = 16;

  localparam int SINE_DEPTH  = 1 << SINE_ADDR_BITS;
  localparam int SAMPLE_W    = 15;
  localparam int CARRIER_W   = 16;
  localparam int DUTY_W      = 16;
  localparam int FIT_W       = (COUNT_BITS > CARRIER_W) ? COUNT_BITS : CARRIER_W;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_DEPTH-1:0][SAMPLE_W-1:0] sine_table_t;

  typedef enum logic {
    KIND_HOLD = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
  } queue_head_t;

  typedef struct packed {
    logic                  done;
    logic [DUTY_W-1:0]     duty;
    logic [COUNT_BITS-1:0] on_cnt;
    logic [COUNT_BITS-1:0] off_cnt;
  } duty_rsp_t;

  // Quarter-wave table, Q2.30 Taylor series, rounded to Q0.15 magnitude.
  function automatic sine_table_t build_sine();
    sine_table_t tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] v;
    tbl = '0;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * SINE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      pos = x;
      neg = '0;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      v = (64'd32767 * s + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tbl[k] = v[SAMPLE_W-1:0];
    end
    return tbl;
  endfunction

  // Clamp a tick count into the counter range, zero becomes one.
  function automatic logic [COUNT_BITS-1:0] fit_count(input logic [CARRIER_W-1:0] c);
    logic [FIT_W-1:0] ce;
    ce = FIT_W'(c);
    if (ce > FIT_W'((1 << COUNT_BITS) - 1)) begin
      ce = FIT_W'((1 << COUNT_BITS) - 1);
    end
    if (ce == '0) begin
      ce = FIT_W'(1);
    end
    return ce[COUNT_BITS-1:0];
  endfunction

endpackage

// ===== hdl/spbd_front.sv =====
`timescale 1ns / 1ps
module spbd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                advance,
  output spbd_pkg::queue_head_t q_head,
  input  logic                q_pop
);
  import spbd_pkg::*;

  // two-entry word queue, classified on entry
  item_kind_t  kinds [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;

  assign q_head.valid = (count != 2'd0);
  assign q_head.kind  = kinds[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      kinds[wr_ptr] <= advance ? KIND_TICK : KIND_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hdl/spbd_duty.sv =====
`timescale 1ns / 1ps
module spbd_duty (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req,
  input  logic [spbd_pkg::PHASE_BITS-1:0] phase,
  input  logic [31:0]                     lead_offset,
  input  logic [15:0]                     mod_index,
  input  logic [spbd_pkg::CARRIER_W-1:0]  carrier_ticks,
  output spbd_pkg::duty_rsp_t             rsp
);
  import spbd_pkg::*;

  localparam sine_table_t SINE_ROM = build_sine();

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_READ = 6'b000010,
    D_MUL  = 6'b000100,
    D_DUTY = 6'b001000,
    D_CNT  = 6'b010000,
    D_FIT  = 6'b100000
  } duty_state_t;

  duty_state_t state;

  logic [PHASE_BITS-1:0]     pa;
  logic [PHASE_BITS-1:0]     pb;
  logic [SINE_ADDR_BITS-1:0] addr_a;
  logic [SINE_ADDR_BITS-1:0] addr_b;
  logic [SAMPLE_W-1:0]       rom_a;
  logic [SAMPLE_W-1:0]       rom_b;
  logic                      neg_a;
  logic                      neg_b;
  logic signed [16:0]        samp_a;
  logic signed [16:0]        samp_b;
  logic signed [16:0]        samp_sum;
  logic signed [33:0]        prod;
  logic signed [34:0]        biased;
  logic [17:0]               duty_full;
  logic [DUTY_W-1:0]         duty;
  logic [31:0]               on_prod;
  logic [CARRIER_W-1:0]      on_raw;
  logic [CARRIER_W-1:0]      off_raw;

  // quadrant in the top two bits; odd quadrants mirror the index
  assign addr_a = pa[PHASE_BITS-2] ? ~pa[PHASE_BITS-3 -: SINE_ADDR_BITS]
                                   :  pa[PHASE_BITS-3 -: SINE_ADDR_BITS];
  assign addr_b = pb[PHASE_BITS-2] ? ~pb[PHASE_BITS-3 -: SINE_ADDR_BITS]
                                   :  pb[PHASE_BITS-3 -: SINE_ADDR_BITS];

  assign samp_a   = neg_a ? -$signed({2'b00, rom_a}) : $signed({2'b00, rom_a});
  assign samp_b   = neg_b ? -$signed({2'b00, rom_b}) : $signed({2'b00, rom_b});
  assign samp_sum = samp_a + samp_b;

  assign biased    = 35'(prod) + (35'sd1 <<< 32);
  assign duty_full = biased[34:17];

  // off = c - ceil(d*c / 2^16)
  assign on_raw  = on_prod[31:16];
  assign off_raw = carrier_ticks - on_raw - CARRIER_W'(|on_prod[15:0]);

  assign rsp.done    = (state == D_FIT);
  assign rsp.duty    = duty;
  assign rsp.on_cnt  = fit_count(on_raw);
  assign rsp.off_cnt = fit_count(off_raw);

  // sine ROM, two read ports, registered data
  always_ff @(posedge clk) begin
    rom_a <= SINE_ROM[addr_a];
    rom_b <= SINE_ROM[addr_b];
    neg_a <= pa[PHASE_BITS-1];
    neg_b <= pb[PHASE_BITS-1];
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        pa <= phase;
        pb <= phase + PHASE_BITS'(lead_offset);
      end
      D_MUL: begin
        prod <= $signed({1'b0, mod_index}) * samp_sum;
      end
      D_DUTY: begin
        duty <= (duty_full > 18'd65535) ? 16'hFFFF : duty_full[15:0];
      end
      D_CNT: begin
        on_prod <= duty * carrier_ticks;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE:  state <= req ? D_READ : D_IDLE;
        D_READ:  state <= D_MUL;
        D_MUL:   state <= D_DUTY;
        D_DUTY:  state <= D_CNT;
        D_CNT:   state <= D_FIT;
        D_FIT:   state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/spbd_back.sv =====
`timescale 1ns / 1ps
`include "sine_pwm_bridge_driver_macros.svh"
module spbd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  spbd_pkg::queue_head_t          q_head,
  output logic                           q_pop,
  input  logic [31:0]                    phase_step,
  output logic                           duty_req,
  output logic [spbd_pkg::PHASE_BITS-1:0] phase_acc,
  input  spbd_pkg::duty_rsp_t            rsp,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic                           bridge_on,
  output logic                           period_start,
  output logic [spbd_pkg::DUTY_W-1:0]    duty_now
);
  import spbd_pkg::*;

  typedef enum logic [1:0] {
    B_RUN  = 2'b01,
    B_WAIT = 2'b10
  } back_state_t;

  back_state_t           state;
  logic [COUNT_BITS-1:0] ticks_left;
  logic [COUNT_BITS-1:0] ticks_next;
  logic [COUNT_BITS-1:0] pending_off_ticks;
  logic                  in_on_phase;
  logic                  drive_level;
  logic [DUTY_W-1:0]     current_duty;
  logic                  out_free;

  assign out_free   = !m_tvalid || m_tready;
  assign q_pop      = (state == B_RUN) && q_head.valid && out_free;
  assign ticks_next = ticks_left - COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= B_RUN;
      phase_acc         <= '0;
      ticks_left        <= COUNT_BITS'(1);
      pending_off_ticks <= '0;
      in_on_phase       <= 1'b0;
      drive_level       <= 1'b1;
      current_duty      <= '0;
      duty_req          <= 1'b0;
      m_tvalid          <= 1'b0;
      bridge_on         <= 1'b0;
      period_start      <= 1'b0;
      duty_now          <= '0;
    end else begin
      duty_req <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_RUN: begin
          if (q_pop) begin
            if (q_head.kind == KIND_HOLD) begin
              m_tvalid     <= 1'b1;
              bridge_on    <= drive_level;
              period_start <= 1'b0;
              duty_now     <= current_duty;
            end else begin
              phase_acc <= phase_acc + PHASE_BITS'(phase_step);
              if (ticks_next != '0) begin
                ticks_left   <= ticks_next;
                m_tvalid     <= 1'b1;
                bridge_on    <= drive_level;
                period_start <= 1'b0;
                duty_now     <= current_duty;
              end else if (in_on_phase) begin
                drive_level  <= 1'b0;
                in_on_phase  <= 1'b0;
                ticks_left   <= (pending_off_ticks != '0) ? pending_off_ticks
                                                          : COUNT_BITS'(1);
                m_tvalid     <= 1'b1;
                bridge_on    <= 1'b0;
                period_start <= 1'b0;
                duty_now     <= current_duty;
              end else begin
                // new carrier period: duty unit reads the advanced phase
                duty_req <= 1'b1;
                state    <= B_WAIT;
              end
            end
          end
        end
        B_WAIT: begin
          if (rsp.done) begin
            current_duty      <= rsp.duty;
            ticks_left        <= rsp.on_cnt;
            pending_off_ticks <= rsp.off_cnt;
            drive_level       <= 1'b1;
            in_on_phase       <= 1'b1;
            m_tvalid          <= 1'b1;
            bridge_on         <= 1'b1;
            period_start      <= 1'b1;
            duty_now          <= rsp.duty;
            state             <= B_RUN;
          end
        end
        default: state <= B_RUN;
      endcase
    end
  end

  `SPBD_ASSERT_IMP(a_ticks_nonzero, 1'b1, ticks_left != '0, "tick counter reached zero")
  `SPBD_ASSERT_IMP(a_done_when_wait, rsp.done, state == B_WAIT, "duty result while not waiting")
  `SPBD_ASSERT_NXT(a_done_emits, rsp.done, m_tvalid && period_start && bridge_on,
                   "period start word not issued")
  `SPBD_ASSERT_IMP(a_pop_slot, q_pop, !(m_tvalid && !m_tready), "pop with output word held")
  `SPBD_ASSERT_IMP(a_wait_no_word, state == B_WAIT, !m_tvalid, "output word during duty wait")

endmodule

// ===== hdl/sine_pwm_bridge_driver.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake                     Payload
// s_*       in   s_tvalid / s_tready           s_tdata[0] advance
// m_*       out  m_tvalid / m_tready           m_tdata[0] bridge_on, [16:1] duty_now;
//                                              m_tuser period_start
// APB       in   psel, penable, pwrite, pready 0x0 phase_step, 0x4 lead_offset,
//                                              0x8 mod_index, 0xC carrier_ticks
//
// The tick engine pops hold words and ordinary ticks straight from the queue whenever the output word is free.
// A tick that opens a carrier period waits for the duty unit, which runs
// ROM read, sum and multiply, clamp, count multiply and count fit in turn.
// Reset is synchronous and active high; it restores the register defaults.
// The two-word input queue keeps accepting while the output word stalls, until it is full.
module sine_pwm_bridge_driver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] advance, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] bridge_on, [16:1] duty_now, [23:17] zero
  output logic        m_tuser,   // [0] period_start
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import spbd_pkg::*;

  typedef enum logic [1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_LEAD_OFFSET   = 2'd1,
    REG_MOD_INDEX     = 2'd2,
    REG_CARRIER_TICKS = 2'd3
  } reg_index_t;

  logic [31:0]           phase_step;
  logic [31:0]           lead_offset;
  logic [15:0]           mod_index;
  logic [CARRIER_W-1:0]  carrier_ticks;
  logic                  cfg_write;
  reg_index_t            reg_sel;

  queue_head_t           q_head;
  logic                  q_pop;
  logic                  duty_req;
  logic [PHASE_BITS-1:0] phase_acc;
  duty_rsp_t             rsp;
  logic                  bridge_on;
  logic                  period_start;
  logic [DUTY_W-1:0]     duty_now;

  // register file: one 32-bit slot per register, word aligned
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= 32'd21475;
      lead_offset   <= 32'd3067834;
      mod_index     <= 16'd53292;
      carrier_ticks <= CARRIER_W'(100);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_PHASE_STEP:    phase_step    <= pwdata;
        REG_LEAD_OFFSET:   lead_offset   <= pwdata;
        REG_MOD_INDEX:     mod_index     <= pwdata[15:0];
        REG_CARRIER_TICKS: carrier_ticks <= pwdata[CARRIER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PHASE_STEP:    prdata = phase_step;
      REG_LEAD_OFFSET:   prdata = lead_offset;
      REG_MOD_INDEX:     prdata = {16'd0, mod_index};
      REG_CARRIER_TICKS: prdata = 32'(carrier_ticks);
      default:           prdata = '0;
    endcase
  end

  // front: accept and classify words into a short queue
  spbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .advance  (s_tdata[0]),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // back: tick engine, carrier state and output word
  spbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .phase_step   (phase_step),
    .duty_req     (duty_req),
    .phase_acc    (phase_acc),
    .rsp          (rsp),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .bridge_on    (bridge_on),
    .period_start (period_start),
    .duty_now     (duty_now)
  );

  // duty unit: sine lookup and on/off counts once per carrier period
  spbd_duty u_duty (
    .clk           (clk),
    .rst           (rst),
    .req           (duty_req),
    .phase         (phase_acc),
    .lead_offset   (lead_offset),
    .mod_index     (mod_index),
    .carrier_ticks (carrier_ticks),
    .rsp           (rsp)
  );

  assign m_tdata = {7'd0, duty_now, bridge_on};
  assign m_tuser = period_start;

endmodule
